FILE: sv/lfu_pkg.sv
// Shared constants and types for the LFU page replacement block.
// Used by lfu_page_replacement_top; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

	localparam int FRAMES     = 4;
	localparam int PAGES      = 32;
	localparam int COUNT_BITS = 16;
	localparam int TIME_BITS  = 16;

	localparam int PAGE_W   = 5;
	localparam int SLOT_W   = 2;
	localparam int CFG_W    = 3;
	localparam int TOTAL_W  = 16;
	localparam int PAGE_IW  = $clog2(PAGES);
	localparam int SLOT_IW  = $clog2(FRAMES) > 0 ? $clog2(FRAMES) : 1;
	localparam int ISSUE_W  = $clog2(FRAMES + 1);
	localparam int ENTRY_W  = COUNT_BITS + TIME_BITS;

	localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(3);

	typedef logic [PAGE_IW-1:0]    page_idx_t;
	typedef logic [SLOT_IW-1:0]    slot_idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [TIME_BITS-1:0]  stamp_t;
	typedef logic [TOTAL_W-1:0]    total_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_UPDATE = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

endpackage

`default_nettype wire

FILE: sv/lfu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the per-page count and stamp store.
`timescale 1ns / 1ps
`default_nettype none

module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/lfu_page_replacement_top.sv
// Top level of the LFU page replacement block: frame table, sequencer and result register.
// Depends on lfu_pkg and lfu_ram.
`timescale 1ns / 1ps
`default_nettype none

// One page request enters at a time. A hit or a fill goes from the update state through the
// result state into the result register. A miss passes through the victim scan in between,
// since the use count and stamp of each resident page are read one per cycle from the single
// read port of the page store. The next request can be taken once the result
// register is loaded. A finished result waits in its own register, so the next request
// is taken while it is still stalled. Reset clears everything at once: the page store has a
// valid bit per entry and an entry never written reads as zero.
module lfu_page_replacement_top
	import lfu_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [lfu_pkg::CFG_W-1:0]    frames_in_use,
	input  wire logic                         page_valid,
	output logic                              page_stall,
	input  wire logic [lfu_pkg::PAGE_W-1:0]   page_number,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic                              hit,
	output logic      [lfu_pkg::SLOT_W-1:0]   slot,
	output logic                              evicted_valid,
	output logic      [lfu_pkg::PAGE_W-1:0]   evicted_page,
	output logic      [lfu_pkg::TOTAL_W-1:0]  hit_total,
	output logic      [lfu_pkg::TOTAL_W-1:0]  fault_total
);

	state_t                state_q;
	logic [CFG_W-1:0]      frames_q;
	logic [FRAMES-1:0]     slot_vld_q;
	page_idx_t             slot_page_q [FRAMES];
	logic [PAGES-1:0]      ent_vld_q;
	stamp_t                clock_q;
	stamp_t                now_q;
	total_t                hits_q;
	total_t                faults_q;
	page_idx_t             page_q;

	logic [ISSUE_W-1:0]    issue_q;
	logic                  rd_pend_s1;
	slot_idx_t             rd_slot_s1;
	logic                  rd_vld_s1;

	count_t                best_cnt_q;
	stamp_t                best_age_q;
	stamp_t                best_stamp_q;
	slot_idx_t             best_slot_q;

	logic                  res_hit_q;
	slot_idx_t             res_slot_q;
	logic                  res_ev_q;
	page_idx_t             res_evp_q;

	logic                  out_vld_q;
	logic                  out_hit_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic                  out_ev_q;
	logic [PAGE_W-1:0]     out_evp_q;
	total_t                out_hits_q;
	total_t                out_faults_q;

	logic                  accept;
	slot_idx_t             last_slot;
	logic                  issue_ok;
	logic                  ram_we;
	page_idx_t             ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic                  ram_re;
	page_idx_t             ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;
	count_t                rd_cnt;
	stamp_t                rd_stamp;
	count_t                new_cnt;
	logic                  found;
	logic                  found_hit;
	slot_idx_t             found_slot;
	stamp_t                rd_age;
	logic                  take;
	count_t                cand_cnt;
	stamp_t                cand_age;
	stamp_t                cand_stamp;
	slot_idx_t             cand_slot;
	logic                  scan_done;
	logic                  out_free;

	assign cfg_ready  = 1'b1;
	assign page_stall = (state_q != ST_IDLE);
	assign accept     = page_valid && !page_stall;
	assign out_free   = !out_vld_q || !result_stall;

	always_comb begin
		if (frames_q == '0) begin
			last_slot = '0;
		end else if (frames_q > CFG_W'(FRAMES)) begin
			last_slot = SLOT_IW'(FRAMES - 1);
		end else begin
			last_slot = SLOT_IW'(frames_q - CFG_W'(1));
		end
	end

	assign rd_cnt   = rd_vld_s1 ? ram_rdata[ENTRY_W-1:TIME_BITS] : '0;
	assign rd_stamp = rd_vld_s1 ? ram_rdata[TIME_BITS-1:0] : '0;
	assign new_cnt  = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
	assign rd_age   = now_q - rd_stamp;

	always_comb begin
		found      = 1'b0;
		found_hit  = 1'b0;
		found_slot = '0;
		for (int j = 0; j < FRAMES; j++) begin
			if (!found && SLOT_IW'(j) <= last_slot &&
			    (!slot_vld_q[j] || slot_page_q[j] == page_q)) begin
				found      = 1'b1;
				found_hit  = slot_vld_q[j];
				found_slot = SLOT_IW'(j);
			end
		end
	end

	assign take = (rd_slot_s1 == '0) || (rd_cnt < best_cnt_q) ||
	              (rd_cnt == best_cnt_q && rd_age > best_age_q);
	assign cand_cnt   = take ? rd_cnt : best_cnt_q;
	assign cand_age   = take ? rd_age : best_age_q;
	assign cand_stamp = take ? rd_stamp : best_stamp_q;
	assign cand_slot  = take ? rd_slot_s1 : best_slot_q;
	assign scan_done  = (state_q == ST_SCAN) && rd_pend_s1 && (rd_slot_s1 == last_slot);
	assign issue_ok   = (state_q == ST_SCAN) && (issue_q <= ISSUE_W'(last_slot));

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = page_number[PAGE_IW-1:0];
		if (accept) begin
			ram_re = 1'b1;
		end else if (issue_ok) begin
			ram_re    = 1'b1;
			ram_raddr = slot_page_q[issue_q[SLOT_IW-1:0]];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = page_q;
		ram_wdata = {new_cnt, now_q};
		if (state_q == ST_UPDATE) begin
			ram_we = 1'b1;
		end else if (scan_done) begin
			ram_we    = 1'b1;
			ram_waddr = slot_page_q[cand_slot];
			ram_wdata = {COUNT_BITS'(0), cand_stamp};
		end
	end

	lfu_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PAGES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frames_q     <= FRAMES_RESET;
			slot_vld_q   <= '0;
			for (int j = 0; j < FRAMES; j++) begin
				slot_page_q[j] <= '0;
			end
			ent_vld_q    <= '0;
			clock_q      <= '0;
			hits_q       <= '0;
			faults_q     <= '0;
			issue_q      <= '0;
			rd_pend_s1   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frames_q <= frames_in_use;
			end
			if (ram_we) begin
				ent_vld_q[ram_waddr] <= 1'b1;
			end
			rd_pend_s1 <= issue_ok;
			if (issue_ok) begin
				issue_q <= issue_q + ISSUE_W'(1);
			end
			if (state_q == ST_RESULT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					clock_q <= clock_q + TIME_BITS'(1);
					if (found) begin
						slot_vld_q[found_slot]  <= 1'b1;
						slot_page_q[found_slot] <= page_q;
						if (found_hit) begin
							if (hits_q != '1) begin
								hits_q <= hits_q + TOTAL_W'(1);
							end
						end else if (faults_q != '1) begin
							faults_q <= faults_q + TOTAL_W'(1);
						end
						state_q <= ST_RESULT;
					end else begin
						if (faults_q != '1) begin
							faults_q <= faults_q + TOTAL_W'(1);
						end
						issue_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						slot_page_q[cand_slot] <= page_q;
						state_q                <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page_number[PAGE_IW-1:0];
			now_q  <= clock_q;
		end
		if (ram_re) begin
			rd_vld_s1  <= ent_vld_q[ram_raddr];
			rd_slot_s1 <= issue_q[SLOT_IW-1:0];
		end
		if (state_q == ST_UPDATE && found) begin
			res_hit_q  <= found_hit;
			res_slot_q <= found_slot;
			res_ev_q   <= 1'b0;
			res_evp_q  <= '0;
		end
		if (state_q == ST_SCAN && rd_pend_s1) begin
			best_cnt_q   <= cand_cnt;
			best_age_q   <= cand_age;
			best_stamp_q <= cand_stamp;
			best_slot_q  <= cand_slot;
		end
		if (scan_done) begin
			res_hit_q  <= 1'b0;
			res_slot_q <= cand_slot;
			res_ev_q   <= 1'b1;
			res_evp_q  <= slot_page_q[cand_slot];
		end
		if (state_q == ST_RESULT && out_free) begin
			out_hit_q    <= res_hit_q;
			out_slot_q   <= SLOT_W'(res_slot_q);
			out_ev_q     <= res_ev_q;
			out_evp_q    <= PAGE_W'(res_evp_q);
			out_hits_q   <= hits_q;
			out_faults_q <= faults_q;
		end
	end

	assign result_valid  = out_vld_q;
	assign hit           = out_hit_q;
	assign slot          = out_slot_q;
	assign evicted_valid = out_ev_q;
	assign evicted_page  = out_evp_q;
	assign hit_total     = out_hits_q;
	assign fault_total   = out_faults_q;

	// The page store is written only while a request is being worked on.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_UPDATE || state_q == ST_SCAN))
		else $error("page store written outside a request");

	// A new result appears only when the sequencer hands one over.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_RESULT))
		else $error("result appeared without a finished request");

	// A hit never evicts a page.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_hit_q && out_ev_q))
		else $error("hit reported together with an eviction");

	// The victim scan never reads past the active frames.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rd_pend_s1) |-> (rd_slot_s1 <= last_slot))
		else $error("victim scan beyond the active frames");

endmodule

`default_nettype wire
